### rtl/clnseq_pkg.sv
// Package for the character LCD nibble sequencer: payload structs, register
// indexes, LCD command bytes and the phase tables. No dependencies.
package clnseq_pkg;

  localparam int HOLD_W      = 17;
  localparam int CFG_INDEX_W = 3;
  localparam int PHASE_W     = 5;   // phase index, up to 28 for the init sequence

  // Operation codes
  localparam logic [1:0] OP_INIT       = 2'd0;
  localparam logic [1:0] OP_CLEAR      = 2'd1;
  localparam logic [1:0] OP_SET_CURSOR = 2'd2;
  localparam logic [1:0] OP_WRITE_CHAR = 2'd3;

  // Register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_HIGH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POWERUP     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_WAKE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NEXT_WAKE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_WAIT  = 3'd5;

  // Register reset values
  localparam logic [HOLD_W-1:0] RST_ENABLE_HIGH = 17'd600;
  localparam logic [HOLD_W-1:0] RST_ENABLE_LOW  = 17'd1200;
  localparam logic [HOLD_W-1:0] RST_POWERUP     = 17'd120000;
  localparam logic [HOLD_W-1:0] RST_FIRST_WAKE  = 17'd40000;
  localparam logic [HOLD_W-1:0] RST_NEXT_WAKE   = 17'd12000;
  localparam logic [HOLD_W-1:0] RST_CLEAR_WAIT  = 17'd60000;

  // LCD command bytes and init nibbles
  localparam logic [3:0] NIB_WAKE         = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;

  typedef struct packed {
    logic [1:0] operation;
    logic       row;
    logic [3:0] column;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic              select_level;
    logic              enable_level;
    logic [3:0]        data_nibble;
    logic [HOLD_W-1:0] hold_cycles;
    logic              last;
  } out_item_t;

  // Which register supplies the hold time of a phase
  typedef enum logic [2:0] {
    HOLD_EN_HIGH,
    HOLD_EN_LOW,
    HOLD_POWERUP,
    HOLD_FIRST_WAKE,
    HOLD_NEXT_WAKE,
    HOLD_CLEAR
  } hold_sel_t;

  typedef struct packed {
    logic       en;
    logic [3:0] nib;
    hold_sel_t  hold;
    logic       last;
  } phase_t;

  function automatic phase_t ph_hi(logic [3:0] nib);
    phase_t p;
    p = '{en: 1'b1, nib: nib, hold: HOLD_EN_HIGH, last: 1'b0};
    return p;
  endfunction

  function automatic phase_t ph_lo(logic [3:0] nib);
    phase_t p;
    p = '{en: 1'b0, nib: nib, hold: HOLD_EN_LOW, last: 1'b0};
    return p;
  endfunction

  function automatic phase_t ph_wait(logic [3:0] nib, hold_sel_t hold);
    phase_t p;
    p = '{en: 1'b0, nib: nib, hold: hold, last: 1'b0};
    return p;
  endfunction

  // Power-up init: 29 phases
  function automatic phase_t init_phase(logic [PHASE_W-1:0] idx);
    phase_t p;
    case (idx)
      0:       p = ph_wait(4'h0, HOLD_POWERUP);
      1:       p = ph_hi(NIB_WAKE);
      2:       p = ph_lo(NIB_WAKE);
      3:       p = ph_wait(NIB_WAKE, HOLD_FIRST_WAKE);
      4:       p = ph_hi(NIB_WAKE);
      5:       p = ph_lo(NIB_WAKE);
      6:       p = ph_wait(NIB_WAKE, HOLD_NEXT_WAKE);
      7:       p = ph_hi(NIB_WAKE);
      8:       p = ph_lo(NIB_WAKE);
      9:       p = ph_wait(NIB_WAKE, HOLD_NEXT_WAKE);
      10:      p = ph_hi(NIB_FOUR_BIT);
      11:      p = ph_lo(NIB_FOUR_BIT);
      12:      p = ph_hi(CMD_FUNCTION_SET[7:4]);
      13:      p = ph_lo(CMD_FUNCTION_SET[7:4]);
      14:      p = ph_hi(CMD_FUNCTION_SET[3:0]);
      15:      p = ph_lo(CMD_FUNCTION_SET[3:0]);
      16:      p = ph_hi(CMD_DISPLAY_ON[7:4]);
      17:      p = ph_lo(CMD_DISPLAY_ON[7:4]);
      18:      p = ph_hi(CMD_DISPLAY_ON[3:0]);
      19:      p = ph_lo(CMD_DISPLAY_ON[3:0]);
      20:      p = ph_hi(CMD_ENTRY_MODE[7:4]);
      21:      p = ph_lo(CMD_ENTRY_MODE[7:4]);
      22:      p = ph_hi(CMD_ENTRY_MODE[3:0]);
      23:      p = ph_lo(CMD_ENTRY_MODE[3:0]);
      24:      p = ph_hi(CMD_CLEAR[7:4]);
      25:      p = ph_lo(CMD_CLEAR[7:4]);
      26:      p = ph_hi(CMD_CLEAR[3:0]);
      27:      p = ph_lo(CMD_CLEAR[3:0]);
      28: begin
        p      = ph_wait(CMD_CLEAR[3:0], HOLD_CLEAR);
        p.last = 1'b1;
      end
      default: p = ph_wait(4'h0, HOLD_EN_LOW);
    endcase
    return p;
  endfunction

  // Single-byte commands: hi/lo of the high nibble, then of the low nibble,
  // plus a settle wait for clear.
  function automatic phase_t byte_phase(in_item_t cmd, logic [PHASE_W-1:0] idx);
    logic [7:0] b;
    phase_t     p;
    case (cmd.operation)
      OP_CLEAR:      b = CMD_CLEAR;
      OP_SET_CURSOR: b = CMD_SET_DDRAM | {1'b0, cmd.row, 2'b00, cmd.column};
      default:       b = cmd.character;
    endcase
    if (idx[2]) begin
      p = ph_wait(b[3:0], HOLD_CLEAR);
    end else begin
      p.en   = ~idx[0];
      p.nib  = idx[1] ? b[3:0] : b[7:4];
      p.hold = idx[0] ? HOLD_EN_LOW : HOLD_EN_HIGH;
      p.last = 1'b0;
    end
    if (cmd.operation == OP_CLEAR) begin
      p.last = (idx == PHASE_W'(4));
    end else begin
      p.last = (idx == PHASE_W'(3));
    end
    return p;
  endfunction

endpackage

### rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer: command register, phase
// decode and result register. Depends on clnseq_pkg.
//
// Turns LCD commands (init, clear, set cursor, write character) into a stream
// of timed pin phases for an HD44780-style display on a 4-bit bus. Each
// phase gives RS, E and D7..D4 levels and how many cycles to hold them; the
// block does not time the holds itself, a downstream pin driver does. One
// phase leaves per cycle while out_ready is high. The set cursor
// and write character commands each give 4 phases, clear gives 5 and
// init gives 29. The phase counter kept beside the command
// register steps through them. The next command is taken in the cycle its
// predecessor's last phase enters the result register, so commands run back
// to back. Hold times come from six 17-bit registers written through the
// cfg port (index 0 enable high, 1 enable low, 2 power-up wait, 3 first wake
// wait, 4 next wake wait, 5 clear wait); write them only while idle.
// Indexes 6 and 7 are ignored.
module char_lcd_nibble_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  clnseq_pkg::in_item_t               in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output clnseq_pkg::out_item_t              out_data,
  input  logic                               cfg_write_en,
  input  logic [clnseq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clnseq_pkg::HOLD_W-1:0]      cfg_data
);
  import clnseq_pkg::*;

  // Timing registers
  logic [HOLD_W-1:0] enable_high;
  logic [HOLD_W-1:0] enable_low;
  logic [HOLD_W-1:0] powerup_wait;
  logic [HOLD_W-1:0] first_wake_wait;
  logic [HOLD_W-1:0] next_wake_wait;
  logic [HOLD_W-1:0] clear_wait;

  // Command register and phase counter
  in_item_t           cmd;
  logic               busy;
  logic [PHASE_W-1:0] phase;

  phase_t            cur;
  logic [HOLD_W-1:0] cur_hold;
  logic              step;
  logic              in_xfer;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_high     <= RST_ENABLE_HIGH;
      enable_low      <= RST_ENABLE_LOW;
      powerup_wait    <= RST_POWERUP;
      first_wake_wait <= RST_FIRST_WAKE;
      next_wake_wait  <= RST_NEXT_WAKE;
      clear_wait      <= RST_CLEAR_WAIT;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ENABLE_HIGH: enable_high     <= cfg_data;
        REG_ENABLE_LOW:  enable_low      <= cfg_data;
        REG_POWERUP:     powerup_wait    <= cfg_data;
        REG_FIRST_WAKE:  first_wake_wait <= cfg_data;
        REG_NEXT_WAKE:   next_wake_wait  <= cfg_data;
        REG_CLEAR_WAIT:  clear_wait      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Phase decode for the current command
  always_comb begin
    if (cmd.operation == OP_INIT) begin
      cur = init_phase(phase);
    end else begin
      cur = byte_phase(cmd, phase);
    end
    case (cur.hold)
      HOLD_EN_HIGH:    cur_hold = enable_high;
      HOLD_EN_LOW:     cur_hold = enable_low;
      HOLD_POWERUP:    cur_hold = powerup_wait;
      HOLD_FIRST_WAKE: cur_hold = first_wake_wait;
      HOLD_NEXT_WAKE:  cur_hold = next_wake_wait;
      HOLD_CLEAR:      cur_hold = clear_wait;
      default:         cur_hold = enable_low;
    endcase
  end

  // A phase moves on whenever the result register is free or being emptied
  assign step     = busy && (!out_valid || out_ready);
  assign in_ready = !busy || (step && cur.last);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
    end else if (in_xfer) begin
      busy  <= 1'b1;
      phase <= '0;
    end else if (step) begin
      busy  <= !cur.last;
      phase <= phase + PHASE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.select_level <= (cmd.operation == OP_WRITE_CHAR);
      out_data.enable_level <= cur.en;
      out_data.data_nibble  <= cur.nib;
      out_data.hold_cycles  <= cur_hold;
      out_data.last         <= cur.last;
    end
  end

`ifndef SYNTHESIS
  a_new_cmd_only_at_end: assert property (@(posedge clk) disable iff (rst)
    in_xfer && busy |-> step && cur.last)
    else $error("command taken while previous one still issuing");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> phase <= PHASE_W'(28))
    else $error("phase counter out of range");

  a_last_reaches_output: assert property (@(posedge clk) disable iff (rst)
    step && cur.last |=> out_valid && out_data.last)
    else $error("final phase not flagged at the output");

  a_phase_restarts: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> busy && phase == '0)
    else $error("phase counter not restarted for new command");
`endif

endmodule

### dv/tb.sv
// Self-checking testbench for char_lcd_nibble_sequencer: drives LCD commands,
// predicts every pin phase and checks each result transfer.
// Depends on rtl/clnseq_pkg.sv and rtl/char_lcd_nibble_sequencer.sv.
`timescale 1ns / 1ps

module tb;
  import clnseq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  // indexes 6 and 7 exist on the port but map to no register
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [HOLD_W-1:0]      HOLD_MAX    = 17'h1FFFF;

  // Holds a copy of the hold registers and the queue of pin phases still due.
  class lcd_phase_board;
    logic [HOLD_W-1:0] hold_reg [6];
    out_item_t         pending [$];
    int                errors;

    function new();
      errors = 0;
      reset_regs();
    endfunction

    function void reset_regs();
      hold_reg[REG_ENABLE_HIGH] = RST_ENABLE_HIGH;
      hold_reg[REG_ENABLE_LOW]  = RST_ENABLE_LOW;
      hold_reg[REG_POWERUP]     = RST_POWERUP;
      hold_reg[REG_FIRST_WAKE]  = RST_FIRST_WAKE;
      hold_reg[REG_NEXT_WAKE]   = RST_NEXT_WAKE;
      hold_reg[REG_CLEAR_WAIT]  = RST_CLEAR_WAIT;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [HOLD_W-1:0] val);
      if (idx <= REG_CLEAR_WAIT) begin
        hold_reg[idx] = val;
      end
    endfunction

    function void push_phase(logic sel, logic en, logic [3:0] nib, logic [HOLD_W-1:0] hold);
      out_item_t p;
      p.select_level = sel;
      p.enable_level = en;
      p.data_nibble  = nib;
      p.hold_cycles  = hold;
      p.last         = 1'b0;
      pending.push_back(p);
    endfunction

    // strobe high, then strobe low, same nibble on the pins
    function void push_nibble(logic sel, logic [3:0] nib);
      push_phase(sel, 1'b1, nib, hold_reg[REG_ENABLE_HIGH]);
      push_phase(sel, 1'b0, nib, hold_reg[REG_ENABLE_LOW]);
    endfunction

    function void push_byte(logic sel, logic [7:0] value);
      push_nibble(sel, value[7:4]);
      push_nibble(sel, value[3:0]);
    endfunction

    // Expand one accepted command into its phases.
    function void note_command(in_item_t cmd);
      logic [7:0] addr;
      case (cmd.operation)
        OP_INIT: begin
          push_phase(1'b0, 1'b0, 4'h0, hold_reg[REG_POWERUP]);
          push_nibble(1'b0, NIB_WAKE);
          push_phase(1'b0, 1'b0, NIB_WAKE, hold_reg[REG_FIRST_WAKE]);
          push_nibble(1'b0, NIB_WAKE);
          push_phase(1'b0, 1'b0, NIB_WAKE, hold_reg[REG_NEXT_WAKE]);
          push_nibble(1'b0, NIB_WAKE);
          push_phase(1'b0, 1'b0, NIB_WAKE, hold_reg[REG_NEXT_WAKE]);
          push_nibble(1'b0, NIB_FOUR_BIT);
          push_byte(1'b0, CMD_FUNCTION_SET);
          push_byte(1'b0, CMD_DISPLAY_ON);
          push_byte(1'b0, CMD_ENTRY_MODE);
          push_byte(1'b0, CMD_CLEAR);
          push_phase(1'b0, 1'b0, CMD_CLEAR[3:0], hold_reg[REG_CLEAR_WAIT]);
        end
        OP_CLEAR: begin
          push_byte(1'b0, CMD_CLEAR);
          push_phase(1'b0, 1'b0, CMD_CLEAR[3:0], hold_reg[REG_CLEAR_WAIT]);
        end
        OP_SET_CURSOR: begin
          addr = {4'h0, cmd.column};
          if (cmd.row) begin
            addr = addr + 8'h40;
          end
          push_byte(1'b0, CMD_SET_DDRAM | addr);
        end
        default: begin
          push_byte(1'b1, cmd.character);
        end
      endcase
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) begin
        $display("mismatch: %s", what);
      end
    endtask

    task check_phase(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected phase %p", got));
      end else begin
        want = pending.pop_front();
        if (got.select_level !== want.select_level)
          report_mismatch($sformatf("select_level %b, want %b",
                                    got.select_level, want.select_level));
        if (got.enable_level !== want.enable_level)
          report_mismatch($sformatf("enable_level %b, want %b",
                                    got.enable_level, want.enable_level));
        if (got.data_nibble !== want.data_nibble)
          report_mismatch($sformatf("data_nibble %h, want %h",
                                    got.data_nibble, want.data_nibble));
        if (got.hold_cycles !== want.hold_cycles)
          report_mismatch($sformatf("hold_cycles %0d, want %0d",
                                    got.hold_cycles, want.hold_cycles));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_data;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [HOLD_W-1:0]      cfg_data;

  lcd_phase_board board;
  bit             quiet = 1'b0;   // no idling on either side once set
  int             stall_left = 0;
  int             cycle_count = 0;

  char_lcd_nibble_sequencer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: ready drops at random, in bursts.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result monitor: values read here are those from before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_phase(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t make_cmd(logic [1:0] op, logic row, logic [3:0] col,
                                        logic [7:0] ch);
    in_item_t c;
    c.operation = op;
    c.row       = row;
    c.column    = col;
    c.character = ch;
    return c;
  endfunction

  // Mostly cursor moves and character strings, now and then a clear or init.
  function automatic in_item_t random_command();
    int         pick;
    logic [1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 4)       op = OP_INIT;
    else if (pick < 14) op = OP_CLEAR;
    else if (pick < 40) op = OP_SET_CURSOR;
    else                op = OP_WRITE_CHAR;
    return make_cmd(op, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                    8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [HOLD_W-1:0] random_hold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 17'd1;
      2:       return HOLD_MAX;
      3:       return HOLD_W'($urandom_range(2, 20));
      default: return HOLD_W'($urandom_range(0, 131071));
    endcase
  endfunction

  // Optional idle burst, then hold valid until the transfer.
  task automatic issue_command(input in_item_t cmd);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_command(cmd);
  endtask

  // Sender holds off until every due phase has left the block.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [HOLD_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // Writes all six registers plus the two spare indexes, which must be ignored.
  task automatic program_regs(input logic [HOLD_W-1:0] en_hi, input logic [HOLD_W-1:0] en_lo,
                              input logic [HOLD_W-1:0] pwr, input logic [HOLD_W-1:0] wake1,
                              input logic [HOLD_W-1:0] wake2, input logic [HOLD_W-1:0] clr);
    put_reg(REG_ENABLE_HIGH, en_hi);
    put_reg(REG_ENABLE_LOW, en_lo);
    put_reg(REG_POWERUP, pwr);
    put_reg(REG_FIRST_WAKE, wake1);
    put_reg(REG_NEXT_WAKE, wake2);
    put_reg(REG_CLEAR_WAIT, clr);
    put_reg(REG_SPARE_A, HOLD_W'($urandom_range(0, 131071)));
    put_reg(REG_SPARE_B, HOLD_W'($urandom_range(0, 131071)));
    cfg_write_en <= 1'b0;
  endtask

  task automatic program_random();
    program_regs(random_hold(), random_hold(), random_hold(),
                 random_hold(), random_hold(), random_hold());
  endtask

  initial begin
    board = new();
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_data      <= '0;
    out_ready    <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values: every command and the cursor/character extremes
    issue_command(make_cmd(OP_INIT, 1'b1, 4'hF, 8'hFF));
    issue_command(make_cmd(OP_CLEAR, 1'b0, 4'h0, 8'h00));
    issue_command(make_cmd(OP_SET_CURSOR, 1'b0, 4'h0, 8'h00));
    issue_command(make_cmd(OP_SET_CURSOR, 1'b1, 4'hF, 8'hFF));
    issue_command(make_cmd(OP_SET_CURSOR, 1'b0, 4'hF, 8'h5A));
    issue_command(make_cmd(OP_SET_CURSOR, 1'b1, 4'h0, 8'hA5));
    issue_command(make_cmd(OP_WRITE_CHAR, 1'b0, 4'h0, 8'h00));
    issue_command(make_cmd(OP_WRITE_CHAR, 1'b1, 4'hF, 8'hFF));
    issue_command(make_cmd(OP_WRITE_CHAR, 1'b0, 4'h5, 8'hA5));
    issue_command(make_cmd(OP_WRITE_CHAR, 1'b1, 4'hA, 8'h5A));
    settle();

    // zero waits and zero enable times still give their phases, hold 0
    program_regs('0, '0, '0, '0, '0, '0);
    issue_command(make_cmd(OP_INIT, 1'b0, 4'h0, 8'h00));
    issue_command(make_cmd(OP_CLEAR, 1'b1, 4'hF, 8'hFF));
    issue_command(make_cmd(OP_SET_CURSOR, 1'b1, 4'h7, 8'h3C));
    issue_command(make_cmd(OP_WRITE_CHAR, 1'b0, 4'h3, 8'h41));
    settle();

    // every hold register at full scale
    program_regs(HOLD_MAX, HOLD_MAX, HOLD_MAX, HOLD_MAX, HOLD_MAX, HOLD_MAX);
    issue_command(make_cmd(OP_INIT, 1'b1, 4'h9, 8'h7E));
    issue_command(make_cmd(OP_CLEAR, 1'b0, 4'h2, 8'h10));
    issue_command(make_cmd(OP_SET_CURSOR, 1'b0, 4'hC, 8'hC3));
    issue_command(make_cmd(OP_WRITE_CHAR, 1'b1, 4'h6, 8'h80));
    settle();

    // random commands, a fresh register setting per block of 95
    for (int chunk = 0; chunk < 4; chunk++) begin
      program_random();
      for (int k = 0; k < 95; k++) begin
        if (chunk == 1 && k == 48) begin
          settle();
        end
        if (chunk == 3 && k == 35) begin
          quiet = 1'b1;
        end
        issue_command(random_command());
      end
      settle();
    end

    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (board.pending.size() != 0) begin
        board.report_mismatch($sformatf("%0d phases never arrived", board.pending.size()));
      end
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### char_lcd_nibble_sequencer.f
rtl/clnseq_pkg.sv
rtl/char_lcd_nibble_sequencer.sv
dv/tb.sv
